/* rtl/core/vcli_pkg.sv */
`default_nettype none

package vcli_pkg;

	// Curve size and derived index widths.
	localparam int TABLE_POINTS = 12;
	localparam int SEG_CNT = TABLE_POINTS - 1;
	localparam int PT_W = $clog2(TABLE_POINTS);
	localparam int SEG_W = $clog2(SEG_CNT);

	// Field and datapath widths.
	localparam int UV_W = 24;
	localparam int PCT_W = 7;
	localparam int FRAC_W = 8;
	localparam int CHARGE_W = 15;
	// Widest segment of the curve is below 2^20 microvolts.
	localparam int SPAN_W = 20;
	// Largest dy * offset over the curve is below 2^23.
	localparam int M_W = 23;
	localparam int NUM_W = M_W + FRAC_W;
	// Reciprocals are floor(2^32 / span); with a numerator below 2^32 the
	// estimate is at most one below the true quotient.
	localparam int RECIP_W = 17;
	localparam int RECIP_SHIFT = 32;
	localparam int Q_W = NUM_W + RECIP_W - RECIP_SHIFT;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef logic [UV_W-1:0] uv_t;

	typedef enum logic [1:0] {
		CLAMP_NONE  = 2'd0,
		CLAMP_FULL  = 2'd1,
		CLAMP_EMPTY = 2'd2
	} clamp_t;

	// Pack voltage points (doubled cell voltage), highest first.
	localparam uv_t PT_UV [TABLE_POINTS] = '{
		24'd8000000, 24'd7720000, 24'd7560000, 24'd7440000,
		24'd7340000, 24'd7240000, 24'd7180000, 24'd7140000,
		24'd7080000, 24'd6960000, 24'd6500000, 24'd5600000
	};

	localparam logic [PCT_W-1:0] PT_PCT [TABLE_POINTS] = '{
		7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
		7'd40, 7'd30, 7'd20, 7'd10, 7'd5, 7'd0
	};

	localparam logic [RECIP_W-1:0] SEG_RECIP [SEG_CNT] = '{
		17'd15339, 17'd26843, 17'd35791, 17'd42949, 17'd42949, 17'd71582,
		17'd107374, 17'd71582, 17'd35791, 17'd9336, 17'd4772
	};

	// One classified word passed from the front to the back.
	typedef struct packed {
		clamp_t status;
		logic [SEG_W-1:0] seg;
		logic [PCT_W-1:0] dy;
		logic [PCT_W-1:0] ylo;
		logic [SPAN_W-1:0] off;
	} vcli_item_t;

	function automatic logic [SPAN_W-1:0] seg_span(input logic [SEG_W-1:0] seg);
		logic [PT_W-1:0] hi_idx;
		logic [PT_W-1:0] lo_idx;
		hi_idx = PT_W'(seg);
		lo_idx = PT_W'(seg + 1'b1);
		return SPAN_W'(PT_UV[hi_idx] - PT_UV[lo_idx]);
	endfunction

endpackage

`default_nettype wire

/* rtl/core/vcli_front.sv */
`default_nettype none

module vcli_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  vcli_pkg::uv_t            in_uv,
	output logic                     push,
	output vcli_pkg::vcli_item_t     push_item,
	output logic [1:0]               inflight
);
	import vcli_pkg::*;

	logic                    v_s1;
	uv_t                     uv_s1;
	logic                    v_s2;
	uv_t                     uv_s2;
	logic [TABLE_POINTS-1:0] gt_s2;
	logic                    full_s2;

	logic [TABLE_POINTS-1:0] gt;
	logic                    hit;
	logic [SEG_W-1:0]        seg;
	logic [PT_W-1:0]         hi_idx;
	logic [PT_W-1:0]         lo_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		uv_s1 <= in_uv;
		uv_s2 <= uv_s1;
		gt_s2 <= gt;
		full_s2 <= (uv_s1 >= PT_UV[0]);
	end

	always_comb begin
		for (int k = 0; k < TABLE_POINTS; k++) begin
			gt[k] = (uv_s1 > PT_UV[k]);
		end
	end

	// The segment is the one whose upper point is not below the voltage
	// while its lower point is; the lowest such index wins.
	always_comb begin
		hit = 1'b0;
		seg = '0;
		hi_idx = '0;
		lo_idx = '0;
		for (int k = SEG_CNT - 1; k >= 0; k--) begin
			if (!gt_s2[k] && gt_s2[k+1]) begin
				hit = 1'b1;
				seg = SEG_W'(k);
				hi_idx = PT_W'(k);
				lo_idx = PT_W'(k + 1);
			end
		end
	end

	always_comb begin
		push_item.status = CLAMP_NONE;
		push_item.seg = '0;
		push_item.dy = '0;
		push_item.ylo = '0;
		push_item.off = '0;
		priority if (full_s2) begin
			push_item.status = CLAMP_FULL;
			push_item.ylo = PT_PCT[0];
		end else if (!gt_s2[TABLE_POINTS-1]) begin
			push_item.status = CLAMP_EMPTY;
			push_item.ylo = PT_PCT[TABLE_POINTS-1];
		end else if (hit) begin
			push_item.seg = seg;
			push_item.ylo = PT_PCT[lo_idx];
			push_item.dy = (PT_PCT[hi_idx] >= PT_PCT[lo_idx]) ?
				PT_PCT[hi_idx] - PT_PCT[lo_idx] : '0;
			push_item.off = SPAN_W'(uv_s2 - PT_UV[lo_idx]);
		end
	end

	assign push = v_s2;
	assign inflight = {1'b0, v_s1} + {1'b0, v_s2};

	a_empty_below_top: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !gt_s2[TABLE_POINTS-1] |-> !gt_s2[0])
		else $error("empty clamp with voltage above top point");

	a_interp_hit: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !full_s2 && gt_s2[TABLE_POINTS-1] |-> hit)
		else $error("voltage inside curve but no segment found");

	a_full_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && full_s2 |-> gt_s2[TABLE_POINTS-1])
		else $error("full clamp with voltage at or below bottom point");

endmodule

`default_nettype wire

/* rtl/core/vcli_queue.sv */
`default_nettype none

module vcli_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  vcli_pkg::vcli_item_t     push_item,
	input  wire logic [1:0]          inflight,
	output logic                     pop_valid,
	output vcli_pkg::vcli_item_t     pop_item,
	output logic                     busy
);
	import vcli_pkg::*;

	vcli_item_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                pop;
	logic [QCNT_W:0]     committed;

	// The back end never stalls, so any held word leaves at once.
	assign pop = (count_q != '0);
	assign pop_valid = pop;
	assign pop_item = slot_q[rd_ptr_q];

	// Words already in the front still need room here.
	assign committed = {1'b0, count_q} + (QCNT_W + 1)'(inflight);
	assign busy = (committed >= (QCNT_W + 1)'(QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q < QCNT_W'(QUEUE_DEPTH))
		else $error("queue overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

	a_push_moves_count: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("push did not raise queue count");

endmodule

`default_nettype wire

/* rtl/core/vcli_back.sv */
`default_nettype none

module vcli_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  vcli_pkg::vcli_item_t           in_item,
	output logic                           done,
	output logic [vcli_pkg::CHARGE_W-1:0]  charge_q8,
	output logic [1:0]                     clamp_status
);
	import vcli_pkg::*;

	logic                v_s1, v_s2, v_s3, v_s4;
	clamp_t              status_s1, status_s2, status_s3, status_s4;
	logic [PCT_W-1:0]    ylo_s1, ylo_s2, ylo_s3;
	logic [SEG_W-1:0]    seg_s1, seg_s2;
	logic [M_W-1:0]      m_s1;
	logic [NUM_W-1:0]    num_s2, num_s3;
	logic [Q_W-1:0]      q_s2, q_s3;
	logic [NUM_W-1:0]    qs_s3;
	logic [SPAN_W-1:0]   span_s3;
	logic [CHARGE_W-1:0] charge_s4;

	logic [NUM_W-1:0]         num;
	logic [NUM_W+RECIP_W-1:0] prod;
	logic [NUM_W-1:0]         rem;
	logic [Q_W-1:0]           q_fix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Quotient of num by the segment span comes from the reciprocal
	// estimate, which is low by at most one, plus one correction step.
	assign num = {m_s1, {FRAC_W{1'b0}}};
	assign prod = num * SEG_RECIP[seg_s1];
	assign rem = num_s3 - qs_s3;
	assign q_fix = q_s3 + Q_W'(rem >= NUM_W'(span_s3));

	always_ff @(posedge clk) begin
		status_s1 <= in_item.status;
		ylo_s1 <= in_item.ylo;
		seg_s1 <= in_item.seg;
		m_s1 <= M_W'(in_item.dy) * M_W'(in_item.off);

		status_s2 <= status_s1;
		ylo_s2 <= ylo_s1;
		seg_s2 <= seg_s1;
		num_s2 <= num;
		q_s2 <= prod[RECIP_SHIFT +: Q_W];

		status_s3 <= status_s2;
		ylo_s3 <= ylo_s2;
		num_s3 <= num_s2;
		q_s3 <= q_s2;
		span_s3 <= seg_span(seg_s2);
		qs_s3 <= NUM_W'(q_s2) * NUM_W'(seg_span(seg_s2));

		status_s4 <= status_s3;
		charge_s4 <= CHARGE_W'({ylo_s3, {FRAC_W{1'b0}}}) + CHARGE_W'(q_fix);
	end

	assign done = v_s4;
	assign charge_q8 = charge_s4;
	assign clamp_status = status_s4;

	a_full_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && status_s4 == CLAMP_FULL |->
			charge_s4 == CHARGE_W'({PT_PCT[0], {FRAC_W{1'b0}}}))
		else $error("full clamp with wrong charge");

	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && status_s4 == CLAMP_EMPTY |->
			charge_s4 == CHARGE_W'({PT_PCT[TABLE_POINTS-1], {FRAC_W{1'b0}}}))
		else $error("empty clamp with wrong charge");

	a_estimate_close: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> num_s3 >= qs_s3 && rem < NUM_W'(2 * span_s3))
		else $error("reciprocal estimate off by more than one");

endmodule

`default_nettype wire

/* rtl/core/voltage_to_charge_lut_interp.sv */
// Pack voltage to state of charge by piecewise linear interpolation.
// Throughput: one word per cycle while busy is low; the front compare stages, the
// short queue and the reciprocal multiply-and-correct pipeline of the back each
// take one per cycle.
// The receiver cannot stall; busy rises only if the queue could overfill.
// Reset (arst_n low) empties the pipeline and the queue; no result is lost after.
`default_nettype none

module voltage_to_charge_lut_interp (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [23:0]               pack_voltage_uv,
	output logic                           done,
	output logic [vcli_pkg::CHARGE_W-1:0]  charge_q8,
	output logic [1:0]                     clamp_status
);
	import vcli_pkg::*;

	logic       accept;
	logic       push;
	vcli_item_t push_item;
	logic [1:0] inflight;
	logic       pop_valid;
	vcli_item_t pop_item;

	assign accept = start && !busy;

	vcli_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_uv     (pack_voltage_uv),
		.push      (push),
		.push_item (push_item),
		.inflight  (inflight)
	);

	vcli_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.inflight  (inflight),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.busy      (busy)
	);

	vcli_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (pop_valid),
		.in_item      (pop_item),
		.done         (done),
		.charge_q8    (charge_q8),
		.clamp_status (clamp_status)
	);

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##7 done)
		else $error("accepted word did not complete in seven cycles");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 7))
		else $error("done without a matching accepted word");

	a_charge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> charge_q8 <= CHARGE_W'({PT_PCT[0], {FRAC_W{1'b0}}}))
		else $error("charge above full scale");

endmodule

`default_nettype wire
